/* rtl/cws_pkg.sv */
package cws_pkg;

   localparam int REF_W   = 16;
   localparam int CTX_W   = 64;
   localparam int DELAY_W = 8;
   // delay after the zero fix, compared against the clamped ring length
   localparam int DLY_W   = 9;
   localparam int DATA_W  = 88;

   localparam logic [1:0] MODE_ADD  = 2'd0;
   localparam logic [1:0] MODE_DEF  = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_FIRE = 1'b1;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   // register index, taken from paddr[2]
   localparam logic CSR_RING_LENGTH = 1'b0;
   localparam logic [3:0] RING_RESET = 4'd2;

   typedef struct packed {
      logic [REF_W-1:0] cb_ref;
      logic [CTX_W-1:0] ctx;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_FILL_RD,
      ST_ADD_WR,
      ST_STATUS,
      ST_TICK_CHK,
      ST_DRAIN
   } state_type;

endpackage

/* rtl/cws_mod.sv */
module cws_mod #(
   parameter int SUMW = 5,
   parameter int LW   = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SUMW-1:0] dividend,
   input  logic [LW-1:0]   divisor,
   output logic            done,
   output logic [LW-1:0]   rem
);

   localparam int CW = $clog2(SUMW + 1);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [SUMW-1:0] sh_ff, sh_in;
   logic [LW-1:0]   rem_ff, rem_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [LW:0]     trial;

   // restoring remainder, one dividend bit per cycle
   always_comb begin
      trial  = {rem_ff, sh_ff[SUMW-1]};
      run_in = run_ff;
      sh_in  = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         sh_in  = dividend;
         rem_in = '0;
         cnt_in = CW'(SUMW);
      end else if (run_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? LW'(trial - {1'b0, divisor}) : LW'(trial);
         sh_in  = sh_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/cws_fill_mem.sv */
module cws_fill_mem #(
   parameter int NUM_SLOTS = 8,
   parameter int SW        = 3,
   parameter int FW        = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          re,
   input  logic [SW-1:0] raddr,
   output logic [FW-1:0] rdata,
   input  logic          we,
   input  logic [SW-1:0] waddr,
   input  logic [FW-1:0] wdata
);

   logic [FW-1:0]        mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] vld_ff;
   logic [FW-1:0]        rd_ff;
   logic                 rvld_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   // a slot never written since reset reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[waddr] <= 1'b1;
         end
         if (re) begin
            rvld_ff <= vld_ff[raddr];
         end
      end
   end

   assign rdata = rvld_ff ? rd_ff : '0;

endmodule

/* rtl/cws_entry_mem.sv */
module cws_entry_mem #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  cws_pkg::entry_type wdata,
   input  logic               re,
   input  logic [AW-1:0]      raddr,
   output cws_pkg::entry_type rdata
);

   cws_pkg::entry_type mem [DEPTH];
   cws_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem[raddr];
      end
   end

   assign rdata = rd_ff;

endmodule

/* rtl/delay_wheel_call_scheduler.sv */
// Add: status word in the output register after acceptance (accept, write), once it is free;
//   with the current slot beyond a shrunk ring the slot comes from the remainder unit,
//   with the remainder steps, the done flag and a fill read before the write.
// Tick: accept, slot check, first fired word load, then one word per cycle from the entry
//   memory read unless the receiver stalls; empty slot emits none. One item in flight.
// Reset (synchronous, active high): current slot 0, ring_length 2, fill valid bits cleared.
module delay_wheel_call_scheduler #(
   parameter int NUM_SLOTS    = 8,
   parameter int SLOT_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // callback_ref[15:0], context_req[79:16], delay[87:80]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // status[1:0], fired_ref[17:2], fired_context[81:18], 0
   output logic [0:0]  rsp_tuser,   // kind[0]
   output logic        rsp_tlast,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LW    = $clog2(NUM_SLOTS + 1);
   localparam int SUMW  = LW + 1;
   localparam int FW    = $clog2(SLOT_ENTRIES + 1);
   localparam int DEPTH = NUM_SLOTS * SLOT_ENTRIES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = cws_pkg::DLY_W;

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   cws_pkg::state_type state_ff, state_in;
   logic [SW-1:0]      current_ff, current_in;
   logic [3:0]         ring_ff, ring_in;
   logic [SW-1:0]      slot_ff, slot_in;
   cws_pkg::entry_type ent_ff, ent_in;
   logic [1:0]         status_ff, status_in;
   logic [FW-1:0]      cnt_ff, cnt_in;
   logic [FW-1:0]      idx_ff, idx_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [15:0]        rsp_ref_ff, rsp_ref_in;
   logic [63:0]        rsp_ctx_ff, rsp_ctx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               out_load;

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic              acc;
   logic [1:0]        mode;
   logic [7:0]        d_raw;
   logic [LW-1:0]     len;
   logic [DW-1:0]     d_eff;
   logic              is_add;
   logic              reject;
   logic [SUMW-1:0]   sum;
   logic              fast;
   logic [SW-1:0]     fast_slot;
   logic [LW-1:0]     tick_inc;
   logic [SW-1:0]     tick_slot;
   logic              out_free;
   logic              last_fire;

   assign acc      = req_tvalid && req_tready;
   assign mode     = req_tuser;
   assign d_raw    = req_tdata[87:80];
   assign is_add   = (mode == cws_pkg::MODE_ADD) || (mode == cws_pkg::MODE_DEF);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_fire = (idx_ff + FW'(1)) == cnt_ff;

   // effective ring length, clamped to 1..NUM_SLOTS
   always_comb begin
      if (ring_ff == 4'd0) begin
         len = LW'(1);
      end else if (32'(ring_ff) > 32'(NUM_SLOTS)) begin
         len = LW'(NUM_SLOTS);
      end else begin
         len = LW'(ring_ff);
      end
   end

   // delay 0 counts as 1; default add uses the ring length
   always_comb begin
      if (mode == cws_pkg::MODE_DEF) begin
         d_eff = DW'(len);
      end else if (d_raw == 8'd0) begin
         d_eff = DW'(1);
      end else begin
         d_eff = DW'(d_raw);
      end
   end

   assign reject = (mode == cws_pkg::MODE_ADD) && (d_eff > DW'(len));

   // target slot: one compare-subtract while current < len, remainder unit otherwise
   assign sum       = SUMW'(current_ff) + SUMW'(d_eff);
   assign fast      = LW'(current_ff) < len;
   assign fast_slot = (sum >= SUMW'(len)) ? SW'(sum - SUMW'(len)) : SW'(sum);

   // tick: next slot with wrap (a current slot beyond a shrunk ring wraps to 0)
   assign tick_inc  = LW'(current_ff) + LW'(1);
   assign tick_slot = (tick_inc >= len) ? '0 : SW'(tick_inc);

   // ---------------------------------------------------------------
   // Remainder unit
   // ---------------------------------------------------------------
   logic          mod_start;
   logic          mod_done;
   logic [LW-1:0] mod_rem;

   assign mod_start = (state_ff == cws_pkg::ST_IDLE) && acc && is_add && !reject && !fast;

   cws_mod #(
      .SUMW (SUMW),
      .LW   (LW)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (sum),
      .divisor  (len),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   // ---------------------------------------------------------------
   // Fill count memory (one count per slot)
   // ---------------------------------------------------------------
   logic          fill_re, fill_we;
   logic [SW-1:0] fill_raddr;
   logic [FW-1:0] fill_q, fill_wdata;
   logic          full;

   assign full = fill_q >= FW'(SLOT_ENTRIES);

   cws_fill_mem #(
      .NUM_SLOTS (NUM_SLOTS),
      .SW        (SW),
      .FW        (FW)
   ) u_fill (
      .clock (clock),
      .reset (reset),
      .re    (fill_re),
      .raddr (fill_raddr),
      .rdata (fill_q),
      .we    (fill_we),
      .waddr (slot_ff),
      .wdata (fill_wdata)
   );

   // ---------------------------------------------------------------
   // Entry memory: slot * SLOT_ENTRIES + position
   // ---------------------------------------------------------------
   logic               ent_we, ent_re;
   logic [AW-1:0]      ent_waddr, ent_raddr;
   logic [31:0]        slot_base;
   cws_pkg::entry_type ent_q;

   assign slot_base = 32'(slot_ff) * 32'(SLOT_ENTRIES);
   assign ent_waddr = AW'(slot_base + 32'(fill_q));

   cws_entry_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_entry (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_ff),
      .re    (ent_re),
      .raddr (ent_raddr),
      .rdata (ent_q)
   );

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cws_pkg::ST_IDLE: begin
            if (acc) begin
               if (mode == cws_pkg::MODE_TICK) begin
                  state_in = cws_pkg::ST_TICK_CHK;
               end else if (is_add) begin
                  if (reject) begin
                     state_in = cws_pkg::ST_STATUS;
                  end else if (fast) begin
                     state_in = cws_pkg::ST_ADD_WR;
                  end else begin
                     state_in = cws_pkg::ST_MOD;
                  end
               end
            end
         end
         cws_pkg::ST_MOD: begin
            if (mod_done) begin
               state_in = cws_pkg::ST_FILL_RD;
            end
         end
         cws_pkg::ST_FILL_RD: begin
            state_in = cws_pkg::ST_ADD_WR;
         end
         cws_pkg::ST_ADD_WR, cws_pkg::ST_STATUS: begin
            if (out_free) begin
               state_in = cws_pkg::ST_IDLE;
            end
         end
         cws_pkg::ST_TICK_CHK: begin
            state_in = (fill_q == '0) ? cws_pkg::ST_IDLE : cws_pkg::ST_DRAIN;
         end
         cws_pkg::ST_DRAIN: begin
            if (out_free && last_fire) begin
               state_in = cws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cws_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: datapath and memory controls
   // ---------------------------------------------------------------
   always_comb begin
      req_tready    = (state_ff == cws_pkg::ST_IDLE);
      current_in    = current_ff;
      slot_in       = slot_ff;
      ent_in        = ent_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      fill_re       = 1'b0;
      fill_raddr    = slot_ff;
      fill_we       = 1'b0;
      fill_wdata    = fill_q + FW'(1);
      ent_we        = 1'b0;
      ent_re        = 1'b0;
      ent_raddr     = AW'(slot_base);
      out_load      = 1'b0;
      rsp_kind_in   = cws_pkg::KIND_ADD;
      rsp_status_in = cws_pkg::STAT_OK;
      rsp_ref_in    = '0;
      rsp_ctx_in    = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         cws_pkg::ST_IDLE: begin
            fill_re    = acc;
            fill_raddr = (mode == cws_pkg::MODE_TICK) ? tick_slot : fast_slot;
            if (acc) begin
               ent_in.cb_ref = req_tdata[15:0];
               ent_in.ctx    = req_tdata[79:16];
               status_in     = cws_pkg::STAT_REJECT;
               if (mode == cws_pkg::MODE_TICK) begin
                  current_in = tick_slot;
                  slot_in    = tick_slot;
               end else begin
                  slot_in = fast_slot;
               end
            end
         end
         cws_pkg::ST_MOD: begin
            if (mod_done) begin
               slot_in = SW'(mod_rem);
            end
         end
         cws_pkg::ST_FILL_RD: begin
            fill_re = 1'b1;
         end
         cws_pkg::ST_ADD_WR: begin
            // append at the tail unless the slot is full
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = full ? cws_pkg::STAT_FULL : cws_pkg::STAT_OK;
               fill_we       = !full;
               ent_we        = !full;
            end
         end
         cws_pkg::ST_STATUS: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_status_in = status_ff;
            end
         end
         cws_pkg::ST_TICK_CHK: begin
            cnt_in = fill_q;
            idx_in = '0;
            ent_re = (fill_q != '0);
         end
         cws_pkg::ST_DRAIN: begin
            // one word per cycle while the output is free; the next entry read goes out with each load but the last
            rsp_kind_in = cws_pkg::KIND_FIRE;
            rsp_ref_in  = ent_q.cb_ref;
            rsp_ctx_in  = ent_q.ctx;
            rsp_last_in = last_fire;
            ent_raddr   = AW'(slot_base + 32'(idx_ff) + 32'd1);
            fill_wdata  = '0;
            if (out_free) begin
               out_load = 1'b1;
               idx_in   = idx_ff + FW'(1);
               ent_re   = !last_fire;
               fill_we  = last_fire;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   logic csr_wr;
   logic csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];
   assign ring_in    = (csr_wr && (csr_idx == cws_pkg::CSR_RING_LENGTH)) ?
                       csr_pwdata[3:0] : ring_ff;
   assign csr_prdata = (csr_idx == cws_pkg::CSR_RING_LENGTH) ? 32'(ring_ff) : '0;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cws_pkg::ST_IDLE;
         current_ff   <= '0;
         ring_ff      <= cws_pkg::RING_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         current_ff   <= current_in;
         ring_ff      <= ring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      ent_ff    <= ent_in;
      status_ff <= status_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      if (out_load) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_ref_ff    <= rsp_ref_in;
         rsp_ctx_ff    <= rsp_ctx_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ctx_ff, rsp_ref_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_drain_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cws_pkg::ST_DRAIN) |-> (idx_ff < cnt_ff))
      else $error("drain index past slot fill");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_last_in) |=> (state_ff == cws_pkg::ST_IDLE))
      else $error("final word loaded but sequencer not idle");

   a_add_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == cws_pkg::KIND_ADD)) |-> rsp_last_ff)
      else $error("add status word without last");

   a_tick_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cws_pkg::ST_TICK_CHK) |-> (LW'(current_ff) < len))
      else $error("tick left current slot outside ring");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int NUM_SLOTS    = 8;
   localparam int SLOT_ENTRIES = 16;
   // mode 3 has no meaning; the block drops it without a result
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] RING_LENGTH_ADDR = {cws_pkg::CSR_RING_LENGTH, 2'b00};
   // worst case: 16 fired words per tick, each behind a long receiver stall
   localparam int CYCLE_LIMIT   = 600000;
   // covers an empty tick and an add through the remainder path
   localparam int SETTLE_CYCLES = 20;

   // one result word as the scheduler should emit it
   typedef struct {
      logic        kind;
      logic [1:0]  status;
      logic [15:0] fired_ref;
      logic [63:0] fired_ctx;
      logic        last;
   } sched_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;   // callback_ref[15:0], context_req[79:16], delay[87:80]
   logic [1:0]  req_tuser;   // mode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // status[1:0], fired_ref[17:2], fired_context[81:18], 0
   logic [0:0]  rsp_tuser;   // kind[0]
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // wheel mirror: current slot, per-slot fill and stored calls
   logic [3:0]  ring_len;
   int          wheel_slot;
   int          slot_count [NUM_SLOTS];
   logic [15:0] slot_ref   [NUM_SLOTS][SLOT_ENTRIES];
   logic [63:0] slot_ctx   [NUM_SLOTS][SLOT_ENTRIES];

   sched_word_type expected_words[$];
   int          errors;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   delay_wheel_call_scheduler #(
      .NUM_SLOTS    (NUM_SLOTS),
      .SLOT_ENTRIES (SLOT_ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop so a hung handshake cannot run forever
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   function automatic void check_field(input string name, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // ring_length is clamped into 1..NUM_SLOTS before use
   function automatic int ring_eff();
      if (ring_len == 0)
         return 1;
      if (ring_len > NUM_SLOTS)
         return NUM_SLOTS;
      return ring_len;
   endfunction

   function automatic void push_status(input logic [1:0] status);
      sched_word_type w;
      w = '{kind: cws_pkg::KIND_ADD, status: status, fired_ref: '0, fired_ctx: '0,
            last: 1'b1};
      expected_words.push_back(w);
   endfunction

   // advance the mirror by one accepted word and queue what it must emit
   function automatic void predict_wheel(input logic [1:0] mode, input logic [15:0] cb_id,
                                         input logic [63:0] ctx_word, input logic [7:0] dly);
      int len;
      int d;
      int slot;
      sched_word_type w;
      len = ring_eff();
      case (mode)
         cws_pkg::MODE_ADD, cws_pkg::MODE_DEF: begin
            d = (mode == cws_pkg::MODE_DEF) ? len : ((dly == 0) ? 1 : int'(dly));
            if (d > len) begin
               push_status(cws_pkg::STAT_REJECT);   // ring never grows
            end else begin
               slot = (wheel_slot + d) % len;
               if (slot_count[slot] >= SLOT_ENTRIES) begin
                  push_status(cws_pkg::STAT_FULL);
               end else begin
                  slot_ref[slot][slot_count[slot]] = cb_id;
                  slot_ctx[slot][slot_count[slot]] = ctx_word;
                  slot_count[slot]++;
                  push_status(cws_pkg::STAT_OK);
               end
            end
         end
         cws_pkg::MODE_TICK: begin
            // a slot index past a shrunk ring wraps to 0 here
            wheel_slot = (wheel_slot + 1 >= len) ? 0 : wheel_slot + 1;
            for (int i = 0; i < slot_count[wheel_slot]; i++) begin
               w.kind      = cws_pkg::KIND_FIRE;
               w.status    = cws_pkg::STAT_OK;
               w.fired_ref = slot_ref[wheel_slot][i];
               w.fired_ctx = slot_ctx[wheel_slot][i];
               w.last      = (i == slot_count[wheel_slot] - 1);
               expected_words.push_back(w);
            end
            slot_count[wheel_slot] = 0;
         end
         default: ;
      endcase
   endfunction

   // result side: compare each accepted word, then pick the next ready level
   always @(posedge clock) begin
      sched_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d status %0d ref %0h last %0d",
                   rsp_tuser[0], rsp_tdata[1:0], rsp_tdata[17:2], rsp_tlast);
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            check_field("kind", exp_w.kind, rsp_tuser[0]);
            check_field("status", exp_w.status, rsp_tdata[1:0]);
            check_field("fired_ref", exp_w.fired_ref, rsp_tdata[17:2]);
            check_field("fired_context", exp_w.fired_ctx, rsp_tdata[81:18]);
            check_field("last", exp_w.last, rsp_tlast);
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request word; valid stays up afterwards so back-to-back words are possible
   task automatic send_word(input logic [1:0] mode, input logic [15:0] cb_id,
                            input logic [63:0] ctx_word, input logic [7:0] dly);
      // each cycle the sender may idle before presenting the word
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dly, ctx_word, cb_id};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      predict_wheel(mode, cb_id, ctx_word, dly);
   endtask

   // stop sending, let every queued word come out, then let the block settle
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_read(output logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= RING_LENGTH_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write ring_length and read it back
   task automatic csr_write(input logic [3:0] value);
      logic [31:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RING_LENGTH_ADDR;
      csr_pwdata  <= {28'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ring_len = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_read(rd);
      check_field("ring_length", {28'd0, ring_len}, rd);
   endtask

   // reset value of the register, field extremes, reject, default delay,
   // unused mode and a tick on an empty slot
   task automatic test_basics();
      logic [31:0] rd;
      csr_read(rd);
      check_field("ring_length", {28'd0, cws_pkg::RING_RESET}, rd);
      send_word(cws_pkg::MODE_ADD, 16'h0000, 64'h0, 8'd0);      // zero delay acts as one
      send_word(cws_pkg::MODE_ADD, 16'hffff, '1, 8'd2);
      send_word(cws_pkg::MODE_ADD, 16'h5a5a, 64'h0123_4567_89ab_cdef, 8'd3);  // past ring
      send_word(cws_pkg::MODE_ADD, 16'hffff, '1, 8'd255);
      send_word(cws_pkg::MODE_DEF, 16'h1234, 64'hfedc_ba98_7654_3210, 8'hff);
      send_word(MODE_UNUSED, 16'hffff, '1, 8'hff);
      send_word(cws_pkg::MODE_TICK, 16'h0, 64'h0, 8'h0);
      send_word(cws_pkg::MODE_TICK, 16'hffff, '1, 8'hff);
      send_word(cws_pkg::MODE_TICK, 16'h0, 64'h0, 8'h0);       // empty slot, silent
      drain(SETTLE_CYCLES);
   endtask

   // single-slot ring: 17 adds overflow slot 0, then one tick drains 16 calls
   task automatic test_slot_full();
      csr_write(4'd1);
      for (int i = 0; i <= SLOT_ENTRIES; i++)
         send_word((i % 3 == 2) ? cws_pkg::MODE_DEF : cws_pkg::MODE_ADD, 16'($urandom),
                   {$urandom, $urandom}, 8'($urandom_range(0, 1)));
      send_word(cws_pkg::MODE_TICK, 16'h0, 64'h0, 8'h0);
      drain(SETTLE_CYCLES);
   endtask

   // shrink the ring while the current slot is past its new end; the call in
   // slot 7 stays stranded until a later phase grows the ring again
   task automatic test_ring_shrink();
      csr_write(4'd8);
      while (wheel_slot != 6)
         send_word(cws_pkg::MODE_TICK, 16'h0, 64'h0, 8'h0);
      send_word(cws_pkg::MODE_ADD, 16'hbeef, 64'hdead_0000_beef_0001, 8'd1);
      drain(SETTLE_CYCLES);
      csr_write(4'd2);
      send_word(cws_pkg::MODE_ADD, 16'h0f0f, 64'h1111_2222_3333_4444, 8'd1);
      send_word(cws_pkg::MODE_DEF, 16'hf0f0, 64'h5555_6666_7777_8888, 8'd0);
      send_word(cws_pkg::MODE_TICK, 16'h0, 64'h0, 8'h0);
      send_word(cws_pkg::MODE_TICK, 16'h0, 64'h0, 8'h0);
      drain(SETTLE_CYCLES);
   endtask

   // random traffic at one ring setting; state carries over between phases
   task automatic test_random(input logic [3:0] ring_val, input int idle_mode,
                              input int n_items);
      int count;
      int r;
      logic [1:0] mode;
      logic [7:0] dly;
      case (idle_mode)
         0: begin send_idle_pct = 29; recv_idle_pct = 85; end
         1: begin send_idle_pct = 85; recv_idle_pct = 29; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      csr_write(ring_val);
      count = 0;
      while (count < n_items) begin
         r = $urandom_range(99);
         if (r < 3)
            mode = MODE_UNUSED;
         else if (r < 35)
            mode = cws_pkg::MODE_TICK;
         else if (r < 50)
            mode = cws_pkg::MODE_DEF;
         else
            mode = cws_pkg::MODE_ADD;
         // mostly delays around the ring length, sometimes anything
         dly = ($urandom_range(3) != 0) ? 8'($urandom_range(0, ring_eff() + 1))
                                        : 8'($urandom_range(0, 255));
         send_word(mode, 16'($urandom), {$urandom, $urandom}, dly);
         if (mode != MODE_UNUSED)
            count++;
         // hold the sender until the block has emptied once per phase
         if (count == n_items / 2 && mode != MODE_UNUSED)
            drain(0);
      end
      drain(SETTLE_CYCLES);
   endtask

   initial begin
      errors        = 0;
      cycle_count   = 0;
      send_idle_pct = 29;
      recv_idle_pct = 85;
      ring_len      = cws_pkg::RING_RESET;
      wheel_slot    = 0;
      foreach (slot_count[i])
         slot_count[i] = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= cws_pkg::MODE_ADD;
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= RING_LENGTH_ADDR;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_basics();
      test_slot_full();
      test_ring_shrink();
      // settings include the clamped extremes 0 and 15
      test_random(4'd8, 0, 40);
      test_random(4'd0, 0, 40);
      test_random(4'd3, 1, 40);
      test_random(4'd15, 1, 40);
      test_random(4'd1, 2, 40);
      test_random(4'd5, 2, 40);

      drain(SETTLE_CYCLES);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
rtl/cws_pkg.sv
rtl/cws_mod.sv
rtl/cws_fill_mem.sv
rtl/cws_entry_mem.sv
rtl/delay_wheel_call_scheduler.sv
bench/testbench.sv
